// File: src/sms_pkg.sv
// Shared types, constants and register codes for the SPI master shifter.
`default_nettype none

package sms_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CS_SETUP_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CS_HOLD_TICKS = 3'd4;

  localparam logic [15:0] RST_HALF_PERIOD = 16'd4;
  localparam logic [15:0] RST_CS_SETUP_TICKS = 16'd0;
  localparam logic [15:0] RST_CS_HOLD_TICKS = 16'd0;

  localparam logic [7:0] BIT_MASK [8] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
  };

  typedef struct packed {
    logic [15:0] half_period;
    logic        clock_polarity;
    logic        clock_phase;
    logic [15:0] cs_setup_ticks;
    logic [15:0] cs_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic       miso_level;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] tx_bits;
    logic       tx_last;
  } item_t;

endpackage

`default_nettype wire

// File: src/sms_in_if.sv
// Channel carrying one timebase tick with its line and transmit fields.
`default_nettype none

interface sms_in_if;
  logic       valid;
  logic       ready;
  logic       miso_level;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [3:0] tx_bits;
  logic       tx_last;

  modport source (
    output valid, miso_level, tx_valid, tx_byte, tx_bits, tx_last,
    input  ready
  );

  modport sink (
    input  valid, miso_level, tx_valid, tx_byte, tx_bits, tx_last,
    output ready
  );
endinterface

`default_nettype wire

// File: src/sms_out_if.sv
// Channel carrying the pin levels and receive result of one tick.
`default_nettype none

interface sms_out_if;
  logic       valid;
  logic       ready;
  logic       sck;
  logic       mosi;
  logic       cs_n;
  logic       tx_taken;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_last;
  logic       busy_res;

  modport source (
    output valid, sck, mosi, cs_n, tx_taken, rx_valid, rx_byte, rx_last, busy_res,
    input  ready
  );

  modport sink (
    input  valid, sck, mosi, cs_n, tx_taken, rx_valid, rx_byte, rx_last, busy_res,
    output ready
  );
endinterface

`default_nettype wire

// File: src/sms_cfg_if.sv
// Configuration write channel with register index and write data.
`default_nettype none

interface sms_cfg_if;
  import sms_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// File: src/sms_front.sv
// Front end: accepts ticks and normalizes the transmit bit count.
`default_nettype none

module sms_front
  import sms_pkg::*;
(
  sms_in_if.sink tick,
  input  logic   full,
  output logic   push,
  output item_t  item
);

  logic [3:0] bits_norm;

  always_comb begin
    if (tick.tx_bits == 4'd0) begin
      bits_norm = 4'd1;
    end else if (tick.tx_bits > 4'd8) begin
      bits_norm = 4'd8;
    end else begin
      bits_norm = tick.tx_bits;
    end
  end

  assign tick.ready = !full;
  assign push = tick.valid && !full;

  always_comb begin
    item.miso_level = tick.miso_level;
    item.tx_valid   = tick.tx_valid;
    item.tx_byte    = tick.tx_byte;
    item.tx_bits    = bits_norm;
    item.tx_last    = tick.tx_last;
  end

endmodule

`default_nettype wire

// File: src/sms_queue.sv
// Short first-in first-out queue of normalized ticks between front and back.
`default_nettype none

module sms_queue
  import sms_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  not_empty,
  output logic  full,
  output item_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign not_empty = (count != '0);
  assign full = (count == CNT_W'(DEPTH));
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sms_back.sv
// Back end: SPI bit sequencer stepped once per tick, with a registered result.
`default_nettype none

module sms_back
  import sms_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  sms_out_if.source result
);

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_SETUP  = 7'b0000010,
    PH_FIRST  = 7'b0000100,
    PH_SECOND = 7'b0001000,
    PH_WAIT   = 7'b0010000,
    PH_TAIL   = 7'b0100000,
    PH_HOLD   = 7'b1000000
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;
  logic [7:0]  tx_shift;
  logic [7:0]  tx_shift_next;
  logic [7:0]  rx_shift;
  logic [7:0]  rx_shift_next;
  logic [3:0]  bit_index;
  logic [3:0]  bit_index_next;
  logic [3:0]  byte_bits;
  logic [3:0]  byte_bits_next;
  logic        final_byte;
  logic        final_byte_next;
  logic        mosi;
  logic        mosi_next;

  logic        step;
  logic [15:0] half_len;
  logic [3:0]  bit_inc;
  logic [7:0]  rx_sampled;
  logic        do_take;
  logic        do_first;
  logic        taken;
  logic        rxv;
  logic [7:0]  rxb;
  logic        rxl;
  logic        sck_next;

  assign step = q_valid && (!result.valid || result.ready);
  assign q_pop = step;
  assign half_len = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
  assign bit_inc = bit_index + 4'd1;
  assign rx_sampled = q_item.miso_level ? (rx_shift | BIT_MASK[bit_index[2:0]]) : rx_shift;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    bit_index_next  = bit_index;
    byte_bits_next  = byte_bits;
    final_byte_next = final_byte;
    mosi_next       = mosi;
    do_take         = 1'b0;
    do_first        = 1'b0;
    rxv             = 1'b0;
    rxb             = 8'd0;
    rxl             = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (q_item.tx_valid) begin
          do_take = 1'b1;
          if (cfg.cs_setup_ticks == 16'd0) begin
            do_first = 1'b1;
          end else begin
            phase_next      = PH_SETUP;
            tick_count_next = cfg.cs_setup_ticks;
          end
        end
      end
      PH_SETUP: begin
        if (tick_count <= 16'd1) begin
          do_first = 1'b1;
        end else begin
          tick_count_next = tick_count - 16'd1;
        end
      end
      PH_FIRST: begin
        if (tick_count <= 16'd1) begin
          phase_next      = PH_SECOND;
          tick_count_next = half_len;
          rx_shift_next   = rx_sampled;
          if ({1'b0, bit_index} + 5'd1 >= {1'b0, byte_bits}) begin
            rxv = 1'b1;
            rxb = rx_sampled;
            rxl = final_byte;
          end
        end else begin
          tick_count_next = tick_count - 16'd1;
        end
      end
      PH_SECOND: begin
        if (tick_count <= 16'd1) begin
          bit_index_next = bit_inc;
          if (bit_inc < byte_bits) begin
            do_first = 1'b1;
          end else if (final_byte) begin
            phase_next = PH_TAIL;
          end else if (q_item.tx_valid) begin
            do_take  = 1'b1;
            do_first = 1'b1;
          end else begin
            phase_next = PH_WAIT;
          end
        end else begin
          tick_count_next = tick_count - 16'd1;
        end
      end
      PH_WAIT: begin
        if (q_item.tx_valid) begin
          do_take  = 1'b1;
          do_first = 1'b1;
        end
      end
      PH_TAIL: begin
        mosi_next = cfg.clock_polarity;
        if (cfg.cs_hold_ticks == 16'd0) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next      = PH_HOLD;
          tick_count_next = cfg.cs_hold_ticks;
        end
      end
      PH_HOLD: begin
        if (tick_count <= 16'd1) begin
          phase_next = PH_IDLE;
        end else begin
          tick_count_next = tick_count - 16'd1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (do_take) begin
      tx_shift_next   = q_item.tx_byte;
      byte_bits_next  = q_item.tx_bits;
      final_byte_next = q_item.tx_last;
      bit_index_next  = 4'd0;
      rx_shift_next   = 8'd0;
    end
    if (do_first) begin
      phase_next      = PH_FIRST;
      tick_count_next = half_len;
      mosi_next       = tx_shift_next[bit_index_next[2:0]];
    end
  end

  assign taken = do_take;

  always_comb begin
    if (phase_next == PH_FIRST) begin
      sck_next = cfg.clock_polarity ^ cfg.clock_phase;
    end else if (phase_next == PH_SECOND) begin
      sck_next = ~(cfg.clock_polarity ^ cfg.clock_phase);
    end else begin
      sck_next = cfg.clock_polarity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 16'd0;
      tx_shift   <= 8'd0;
      rx_shift   <= 8'd0;
      bit_index  <= 4'd0;
      byte_bits  <= 4'd0;
      final_byte <= 1'b0;
      mosi       <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      tx_shift   <= tx_shift_next;
      rx_shift   <= rx_shift_next;
      bit_index  <= bit_index_next;
      byte_bits  <= byte_bits_next;
      final_byte <= final_byte_next;
      mosi       <= mosi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (step) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.sck      <= sck_next;
      result.mosi     <= mosi_next;
      result.cs_n     <= (phase_next == PH_IDLE);
      result.tx_taken <= taken;
      result.rx_valid <= rxv;
      result.rx_byte  <= rxb;
      result.rx_last  <= rxl;
      result.busy_res <= (phase_next != PH_IDLE);
    end
  end

endmodule

`default_nettype wire

// File: src/spi_master_shifter_core.sv
// Top level of the SPI master shifter: configuration registers, front, queue and back.
// Each accepted tick is queued, then gives one registered result when the output is free.
// Throughput is one tick per cycle unless the output stalls, one sequencer step per tick.
// The queue between front and back holds up to QUEUE_DEPTH ticks during output stalls.
// Synchronous reset idles the sequencer, clears result valid and loads default settings.
`default_nettype none

module spi_master_shifter_core
  import sms_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  sms_in_if.sink     tick,
  sms_cfg_if.sink    cfg,
  sms_out_if.source  result
);

  cfg_t  cfg_regs;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_not_empty;
  logic  q_full;
  item_t q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.half_period    <= RST_HALF_PERIOD;
      cfg_regs.clock_polarity <= 1'b0;
      cfg_regs.clock_phase    <= 1'b0;
      cfg_regs.cs_setup_ticks <= RST_CS_SETUP_TICKS;
      cfg_regs.cs_hold_ticks  <= RST_CS_HOLD_TICKS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_HALF_PERIOD:    cfg_regs.half_period    <= cfg.data;
        CFG_CLOCK_POLARITY: cfg_regs.clock_polarity <= cfg.data[0];
        CFG_CLOCK_PHASE:    cfg_regs.clock_phase    <= cfg.data[0];
        CFG_CS_SETUP_TICKS: cfg_regs.cs_setup_ticks <= cfg.data;
        CFG_CS_HOLD_TICKS:  cfg_regs.cs_hold_ticks  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  sms_front u_front (
    .tick (tick),
    .full (q_full),
    .push (q_push),
    .item (q_push_item)
  );

  sms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  sms_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_not_empty),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .result  (result)
  );

  // A received byte only completes inside a selected transfer.
  a_rx_in_transfer: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.rx_valid) |-> (!result.cs_n && result.busy_res))
    else $error("rx_valid reported outside a selected transfer");

  // Taking a transmit byte always starts or continues a transfer.
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.tx_taken) |-> (result.busy_res && !result.cs_n))
    else $error("tx_taken reported while idle");

  // Receiving and taking a byte happen on different ticks.
  a_rx_take_apart: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.rx_valid && result.tx_taken))
    else $error("rx_valid and tx_taken on the same tick");

  // The queue is never popped while empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire
